// ===== design/sts_pkg.sv =====
`timescale 1ns / 1ps

package sts_pkg;

   localparam int DEFAULT_TABLE_DEPTH = 1024;
   localparam int DEFAULT_VALUE_WIDTH = 32;
   localparam int KEY_WIDTH           = 32;
   localparam int INDEX_WIDTH         = 10;

   localparam logic KIND_WRITE  = 1'b0;
   localparam logic KIND_SEARCH = 1'b1;

   typedef struct packed {
      logic                          kind;
      logic [INDEX_WIDTH-1:0]        entry_index;
      logic signed [KEY_WIDTH-1:0]   entry_value;
      logic signed [KEY_WIDTH-1:0]   search_key;
      logic [INDEX_WIDTH-1:0]        range_low;
      logic [INDEX_WIDTH-1:0]        range_high;
   } req_type;

   typedef struct packed {
      logic                          found;
      logic [INDEX_WIDTH-1:0]        position;
      logic signed [KEY_WIDTH-1:0]   key_echo;
   } rsp_type;

   typedef struct packed {
      logic write;
      logic load;
      logic start;
      logic step;
      logic out_load;
   } dp_cmd_type;

   typedef struct packed {
      logic range_empty;
      logic hit;
      logic next_empty;
   } dp_status_type;

endpackage

// ===== design/sts_datapath.sv =====
`timescale 1ns / 1ps

module sts_datapath #(
   parameter int TABLE_DEPTH = sts_pkg::DEFAULT_TABLE_DEPTH,
   parameter int VALUE_WIDTH = sts_pkg::DEFAULT_VALUE_WIDTH
) (
   input  logic                  clock,
   input  sts_pkg::req_type      req_payload,
   input  sts_pkg::dp_cmd_type   cmd,
   output sts_pkg::dp_status_type status,
   output sts_pkg::rsp_type      rsp_payload
);

   import sts_pkg::*;

   localparam int AW = $clog2(TABLE_DEPTH);
   localparam int IW = ((AW > INDEX_WIDTH) ? AW : INDEX_WIDTH) + 1;

   logic [VALUE_WIDTH-1:0]        mem [0:TABLE_DEPTH-1];
   logic signed [VALUE_WIDTH-1:0] rdata_ff;

   logic [IW-1:0]                 lo_ff, lo_in;
   logic [IW-1:0]                 hi_ff, hi_in;
   logic [IW-1:0]                 mid_ff, mid_in;
   logic signed [VALUE_WIDTH-1:0] key_ff, key_in;
   logic signed [KEY_WIDTH-1:0]   echo_ff, echo_in;
   logic                          found_ff, found_in;
   logic [INDEX_WIDTH-1:0]        pos_ff, pos_in;
   rsp_type                       rsp_ff, rsp_in;

   logic [IW-1:0]                 wr_index;
   logic                          wr_ok;
   logic [IW-1:0]                 hi_raw;
   logic [IW-1:0]                 hi_sat;
   logic [IW-1:0]                 mid_start;
   logic [IW-1:0]                 lo_n, hi_n;
   logic [IW-1:0]                 mid_step;
   logic [IW-1:0]                 rd_mid;
   logic [AW-1:0]                 rd_addr;
   logic                          key_lt, key_gt;

   // write side
   assign wr_index = IW'(req_payload.entry_index);
   assign wr_ok    = wr_index < IW'(TABLE_DEPTH);

   // range set-up, high end clamped to the table
   assign hi_raw = IW'(req_payload.range_high);
   assign hi_sat = (hi_raw > IW'(TABLE_DEPTH - 1)) ? IW'(TABLE_DEPTH - 1) : hi_raw;

   assign mid_start = lo_ff + ((hi_ff - lo_ff) >> 1);

   // one probe: compare, narrow the range, pick the next midpoint
   assign key_lt = key_ff < rdata_ff;
   assign key_gt = key_ff > rdata_ff;

   always_comb begin
      lo_n = lo_ff;
      hi_n = hi_ff;
      if (key_lt) begin
         hi_n = mid_ff - IW'(1);
      end else if (key_gt) begin
         lo_n = mid_ff + IW'(1);
      end
   end

   assign mid_step = lo_n + ((hi_n - lo_n) >> 1);
   assign rd_mid   = cmd.step ? mid_step : mid_start;
   assign rd_addr  = rd_mid[AW-1:0];

   assign status.range_empty = lo_ff > hi_ff;
   assign status.hit         = !key_lt && !key_gt;
   assign status.next_empty  = (key_lt && (mid_ff == '0)) || (lo_n > hi_n);

   always_comb begin
      lo_in    = lo_ff;
      hi_in    = hi_ff;
      mid_in   = mid_ff;
      key_in   = key_ff;
      echo_in  = echo_ff;
      found_in = found_ff;
      pos_in   = pos_ff;
      rsp_in   = rsp_ff;
      if (cmd.load) begin
         lo_in    = IW'(req_payload.range_low);
         hi_in    = hi_sat;
         key_in   = VALUE_WIDTH'(req_payload.search_key);
         echo_in  = req_payload.search_key;
         found_in = 1'b0;
         pos_in   = '0;
      end
      if (cmd.start) begin
         mid_in = mid_start;
      end
      if (cmd.step) begin
         lo_in  = lo_n;
         hi_in  = hi_n;
         mid_in = mid_step;
         if (status.hit) begin
            found_in = 1'b1;
            pos_in   = mid_ff[INDEX_WIDTH-1:0];
         end
      end
      if (cmd.out_load) begin
         rsp_in.found    = found_ff;
         rsp_in.position = pos_ff;
         rsp_in.key_echo = echo_ff;
      end
   end

   always_ff @(posedge clock) begin
      lo_ff    <= lo_in;
      hi_ff    <= hi_in;
      mid_ff   <= mid_in;
      key_ff   <= key_in;
      echo_ff  <= echo_in;
      found_ff <= found_in;
      pos_ff   <= pos_in;
      rsp_ff   <= rsp_in;
   end

   // table, one write and one registered read a cycle
   always_ff @(posedge clock) begin
      if (cmd.write && wr_ok) begin
         mem[wr_index[AW-1:0]] <= VALUE_WIDTH'(req_payload.entry_value);
      end
      rdata_ff <= mem[rd_addr];
   end

   assign rsp_payload = rsp_ff;

endmodule

// ===== design/sts_controller.sv =====
`timescale 1ns / 1ps

module sts_controller (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  logic                   req_kind,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   input  sts_pkg::dp_status_type status,
   output sts_pkg::dp_cmd_type    cmd
);

   import sts_pkg::*;

   typedef enum logic [3:0] {
      ST_IDLE    = 4'b0001,
      ST_START   = 4'b0010,
      ST_SEARCH  = 4'b0100,
      ST_DELIVER = 4'b1000
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      req_beat;

   assign req_ready = (state_ff == ST_IDLE);
   assign req_beat  = req_valid && req_ready;
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_beat) begin
               if (req_kind == KIND_SEARCH) begin
                  cmd.load = 1'b1;
                  state_in = ST_START;
               end else begin
                  cmd.write = 1'b1;
               end
            end
         end
         ST_START: begin
            if (status.range_empty) begin
               state_in = ST_DELIVER;
            end else begin
               cmd.start = 1'b1;
               state_in  = ST_SEARCH;
            end
         end
         ST_SEARCH: begin
            cmd.step = 1'b1;
            if (status.hit || status.next_empty) begin
               state_in = ST_DELIVER;
            end
         end
         ST_DELIVER: begin
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.out_load = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // output register, refilled in the cycle its beat leaves
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.out_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

// ===== design/sorted_table_binary_search.sv =====
// Binary search over a sorted table of signed values.
// Request channel (req_valid / req_ready / req_payload): a beat with kind write
// stores entry_value at entry_index (indexes beyond the table are dropped); a
// beat with kind search looks for search_key in [range_low, range_high], the
// high end clamped to the last table entry.
// Response channel (rsp_valid / rsp_ready / rsp_payload): one beat per search,
// none per write, carrying found, position (0 on a miss) and the key.
// A write keeps req_ready high; the next beat may follow straight away.
// A search holds the request channel through the start step, p probes and the
// delivery of its result, p being the number of probes (0 for an empty range,
// at most clog2(depth + 1), so 11 for 1024 entries); rsp_valid rises as the
// channel reopens. Probes run back to back: the table read port is registered
// and the compare of one probe selects the address of the next.
// The result sits in an output register, so writes and a new search are taken
// while it waits; a search that finishes while the register is still full
// holds until rsp_ready frees it.
// Reset clears the control state and the output valid; table contents are
// undefined until written.
`timescale 1ns / 1ps

module sorted_table_binary_search #(
   parameter int TABLE_DEPTH = sts_pkg::DEFAULT_TABLE_DEPTH,
   parameter int VALUE_WIDTH = sts_pkg::DEFAULT_VALUE_WIDTH
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  sts_pkg::req_type req_payload,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output sts_pkg::rsp_type rsp_payload
);

   import sts_pkg::*;

   dp_cmd_type    cmd;
   dp_status_type status;

   sts_controller u_controller (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_kind  (req_payload.kind),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .status    (status),
      .cmd       (cmd)
   );

   sts_datapath #(
      .TABLE_DEPTH (TABLE_DEPTH),
      .VALUE_WIDTH (VALUE_WIDTH)
   ) u_datapath (
      .clock       (clock),
      .req_payload (req_payload),
      .cmd         (cmd),
      .status      (status),
      .rsp_payload (rsp_payload)
   );

endmodule

// ===== design/sts_checker.sv =====
`timescale 1ns / 1ps

module sts_checker (
   input logic             clock,
   input logic             reset,
   input logic             req_valid,
   input logic             req_ready,
   input sts_pkg::req_type req_payload,
   input logic             rsp_valid,
   input logic             rsp_ready,
   input sts_pkg::rsp_type rsp_payload
);

   import sts_pkg::*;

   logic search_beat;
   logic write_beat;

   assign search_beat = req_valid && req_ready && (req_payload.kind == KIND_SEARCH);
   assign write_beat  = req_valid && req_ready && (req_payload.kind == KIND_WRITE);

   // stalled response holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_payload))
      else $error("response dropped or changed while stalled");

   assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("response valid after reset");

   // the request channel closes once a search is taken
   assert property (@(posedge clock) disable iff (reset)
      search_beat |=> !req_ready)
      else $error("request taken during a search");

   assert property (@(posedge clock) disable iff (reset)
      write_beat |=> req_ready)
      else $error("write stalled the request channel");

   // no result can appear the cycle after a search is taken
   assert property (@(posedge clock) disable iff (reset)
      search_beat |=> !$rose(rsp_valid))
      else $error("response too early after a search");

endmodule

bind sorted_table_binary_search sts_checker u_checker (.*);
